>>> rtl/core/indexed_linked_list_store_unit_assert.svh
// Assertion macros for the indexed linked list store unit.
`ifndef INDEXED_LINKED_LIST_STORE_UNIT_ASSERT_SVH
`define INDEXED_LINKED_LIST_STORE_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define ILLS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ills: assertion failed");

// Next-cycle implication, disabled during reset.
`define ILLS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ills: assertion failed");

`endif

>>> rtl/core/ills_pkg.sv
// Types and constants shared by the indexed linked list store unit.
package ills_pkg;

  localparam int COUNT_W = 7;
  localparam int POS_W   = 8;
  localparam int WORD_W  = 32;

  localparam logic signed [WORD_W-1:0] READ_FAIL = -32'sd1;

  typedef enum logic [1:0] {
    OP_READ     = 2'd0,
    OP_INS_HEAD = 2'd1,
    OP_INS_TAIL = 2'd2,
    OP_REMOVE   = 2'd3
  } ills_op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WALK,
    ST_RD_VAL,
    ST_TAKE,
    ST_INSERT,
    ST_RM_HEAD,
    ST_RM_VIC,
    ST_RM_LINK,
    ST_GIVE,
    ST_RESP
  } ills_state_t;

  typedef struct packed {
    ills_op_t                   opcode;
    logic [POS_W-1:0]           list_position;
    logic signed [WORD_W-1:0]   new_value;
  } ills_in_t;

  typedef struct packed {
    logic signed [WORD_W-1:0]   read_value;
    logic                       ok;
    logic                       full_drop;
    logic [COUNT_W-1:0]         entry_count;
  } ills_out_t;

endpackage

>>> rtl/core/ills_slot_mem.sv
// Slot store: value array and link array, one write port each, shared registered read.
module ills_slot_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6,
  parameter int DW    = 32
) (
  input  logic          clk,
  input  logic          val_we,
  input  logic [AW-1:0] val_waddr,
  input  logic [DW-1:0] val_wdata,
  input  logic          link_we,
  input  logic [AW-1:0] link_waddr,
  input  logic [AW-1:0] link_wdata,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_val_r,
  output logic [AW-1:0] rd_link_r
);

  logic [DW-1:0] val_mem  [DEPTH];
  logic [AW-1:0] link_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (val_we) begin
      val_mem[val_waddr] <= val_wdata;
    end
    if (link_we) begin
      link_mem[link_waddr] <= link_wdata;
    end
    rd_val_r  <= val_mem[rd_addr];
    rd_link_r <= link_mem[rd_addr];
  end

endmodule

>>> rtl/core/indexed_linked_list_store_unit.sv
// Top level of the indexed linked list store unit: sequencer, list registers, result register.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+---------------------------------------
//   in      | input     | in_valid / in_ready    | in_data  (opcode, list_position, new_value)
//   out     | output    | out_valid / out_ready  | out_data (read_value, ok, full_drop, entry_count)
//
// With the output register free, a read walks the links to its position, a remove at p>0
// walks to the predecessor, a head remove or an insert needs no walk (a recycled slot
// passes ST_TAKE first) and a refused request goes straight to the response step. The link
// walk sets the worst case: the slot memory gives one registered link read per cycle. One
// transaction is in work at a time; in_ready is high only when idle, from the cycle the
// result is loaded. Reset (synchronous, active low) clears the list registers; the slot memory
// holds no reset and needs no clearing pass, since only written slots are ever followed.
// A result waits in the output register while out_ready is low; the next transaction may be
// accepted meanwhile and its own result then waits in the response step.

`include "indexed_linked_list_store_unit_assert.svh"

module indexed_linked_list_store_unit #(
  parameter int CAPACITY   = 64,
  parameter int VALUE_BITS = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  ills_pkg::ills_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output ills_pkg::ills_out_t out_data
);

  localparam int SW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = (CW > ills_pkg::POS_W) ? CW : ills_pkg::POS_W;
  localparam int EW = ills_pkg::COUNT_W;
  localparam int XW = ills_pkg::WORD_W;
  localparam int QW = ills_pkg::POS_W;

  // Map any slot code past the store to slot zero.
  function automatic logic [SW-1:0] clamp_slot(input logic [SW-1:0] s);
    return (32'(s) < 32'(CAPACITY)) ? s : '0;
  endfunction

  // Sequencer and list state
  ills_pkg::ills_state_t state_r, state_nxt;
  ills_pkg::ills_op_t    op_r, op_nxt;
  logic [VALUE_BITS-1:0] nv_r, nv_nxt;
  logic [SW-1:0]         head_r, head_nxt;
  logic [SW-1:0]         tail_r, tail_nxt;
  logic [SW-1:0]         free_head_r, free_head_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  logic [CW-1:0]         free_count_r, free_count_nxt;
  logic [CW-1:0]         fresh_r, fresh_nxt;
  // Walk registers: cur is the slot reached, sel is the victim or the new slot
  logic [SW-1:0]         cur_r, cur_nxt;
  logic [SW-1:0]         sel_r, sel_nxt;
  logic [QW-1:0]         steps_r, steps_nxt;
  logic                  hop_r, hop_nxt;
  // Response being built
  logic [XW-1:0]         rsp_value_r, rsp_value_nxt;
  logic                  rsp_ok_r, rsp_ok_nxt;
  logic                  rsp_drop_r, rsp_drop_nxt;
  // Output register
  logic                  out_valid_r, out_valid_nxt;
  ills_pkg::ills_out_t   out_data_r, out_data_nxt;

  // Slot memory port
  logic                  val_we;
  logic [SW-1:0]         val_waddr;
  logic [VALUE_BITS-1:0] val_wdata;
  logic                  link_we;
  logic [SW-1:0]         link_waddr;
  logic [SW-1:0]         link_wdata;
  logic [SW-1:0]         rd_addr;
  logic [VALUE_BITS-1:0] rd_val;
  logic [SW-1:0]         rd_link;

  logic [SW-1:0]         walk_slot;
  logic [SW-1:0]         link_next;
  logic signed [63:0]    val_ext;
  logic                  pos_hit;
  logic                  list_full;
  logic [CW:0]           used_slots;
  logic                  resp_fire;

  ills_slot_mem #(
    .DEPTH (CAPACITY),
    .AW    (SW),
    .DW    (VALUE_BITS)
  ) u_mem (
    .clk        (clk),
    .val_we     (val_we),
    .val_waddr  (val_waddr),
    .val_wdata  (val_wdata),
    .link_we    (link_we),
    .link_waddr (link_waddr),
    .link_wdata (link_wdata),
    .rd_addr    (rd_addr),
    .rd_val_r   (rd_val),
    .rd_link_r  (rd_link)
  );

  assign in_ready  = (state_r == ills_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign link_next  = clamp_slot(rd_link);
  // During a walk the slot just read supplies the next address directly.
  assign walk_slot  = hop_r ? link_next : cur_r;
  assign val_ext    = 64'(signed'(rd_val));
  assign pos_hit    = PW'(in_data.list_position) < PW'(count_r);
  assign list_full  = count_r >= CW'(CAPACITY);
  assign used_slots = (CW+1)'(count_r) + (CW+1)'(free_count_r);
  assign resp_fire  = (state_r == ills_pkg::ST_RESP) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    nv_nxt         = nv_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    free_head_nxt  = free_head_r;
    count_nxt      = count_r;
    free_count_nxt = free_count_r;
    fresh_nxt      = fresh_r;
    cur_nxt        = cur_r;
    sel_nxt        = sel_r;
    steps_nxt      = steps_r;
    hop_nxt        = hop_r;
    rsp_value_nxt  = rsp_value_r;
    rsp_ok_nxt     = rsp_ok_r;
    rsp_drop_nxt   = rsp_drop_r;
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;

    rd_addr    = cur_r;
    val_we     = 1'b0;
    val_waddr  = sel_r;
    val_wdata  = nv_r;
    link_we    = 1'b0;
    link_waddr = sel_r;
    link_wdata = clamp_slot(free_head_r);

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ills_pkg::ST_IDLE: begin
        // Prefetch the link that a head remove or a recycled slot needs.
        rd_addr = (in_data.opcode == ills_pkg::OP_REMOVE) ? clamp_slot(head_r)
                                                          : clamp_slot(free_head_r);
        if (in_valid) begin
          op_nxt        = in_data.opcode;
          nv_nxt        = VALUE_BITS'(in_data.new_value);
          hop_nxt       = 1'b0;
          cur_nxt       = clamp_slot(head_r);
          rsp_value_nxt = '0;
          rsp_ok_nxt    = 1'b0;
          rsp_drop_nxt  = 1'b0;
          unique case (in_data.opcode) inside
            ills_pkg::OP_READ: begin
              if (pos_hit) begin
                steps_nxt = in_data.list_position;
                state_nxt = ills_pkg::ST_WALK;
              end else begin
                rsp_value_nxt = ills_pkg::READ_FAIL;
                state_nxt     = ills_pkg::ST_RESP;
              end
            end
            ills_pkg::OP_INS_HEAD, ills_pkg::OP_INS_TAIL: begin
              if (list_full) begin
                rsp_drop_nxt = 1'b1;
                state_nxt    = ills_pkg::ST_RESP;
              end else if (free_count_r != '0) begin
                sel_nxt   = clamp_slot(free_head_r);
                state_nxt = ills_pkg::ST_TAKE;
              end else begin
                sel_nxt   = fresh_r[SW-1:0];
                fresh_nxt = fresh_r + CW'(1);
                state_nxt = ills_pkg::ST_INSERT;
              end
            end
            ills_pkg::OP_REMOVE: begin
              if (!pos_hit) begin
                state_nxt = ills_pkg::ST_RESP;
              end else if (in_data.list_position == '0) begin
                sel_nxt   = clamp_slot(head_r);
                state_nxt = ills_pkg::ST_RM_HEAD;
              end else begin
                // Walk to the predecessor of the victim.
                steps_nxt = in_data.list_position - QW'(1);
                state_nxt = ills_pkg::ST_WALK;
              end
            end
            default: begin
              state_nxt = ills_pkg::ST_RESP;
            end
          endcase
        end
      end

      ills_pkg::ST_TAKE: begin
        free_head_nxt  = link_next;
        free_count_nxt = free_count_r - CW'(1);
        state_nxt      = ills_pkg::ST_INSERT;
      end

      ills_pkg::ST_INSERT: begin
        val_we = 1'b1;
        if (count_r == '0) begin
          head_nxt = sel_r;
          tail_nxt = sel_r;
        end else if (op_r == ills_pkg::OP_INS_HEAD) begin
          link_we    = 1'b1;
          link_waddr = sel_r;
          link_wdata = clamp_slot(head_r);
          head_nxt   = sel_r;
        end else begin
          link_we    = 1'b1;
          link_waddr = clamp_slot(tail_r);
          link_wdata = sel_r;
          tail_nxt   = sel_r;
        end
        count_nxt  = count_r + CW'(1);
        rsp_ok_nxt = 1'b1;
        state_nxt  = ills_pkg::ST_RESP;
      end

      ills_pkg::ST_WALK: begin
        // One link per cycle; the last read also fetches the value of the slot reached.
        rd_addr = walk_slot;
        if (steps_r == '0) begin
          cur_nxt   = walk_slot;
          hop_nxt   = 1'b0;
          state_nxt = (op_r == ills_pkg::OP_READ) ? ills_pkg::ST_RD_VAL
                                                  : ills_pkg::ST_RM_VIC;
        end else begin
          steps_nxt = steps_r - QW'(1);
          hop_nxt   = 1'b1;
        end
      end

      ills_pkg::ST_RD_VAL: begin
        rsp_value_nxt = val_ext[XW-1:0];
        rsp_ok_nxt    = 1'b1;
        state_nxt     = ills_pkg::ST_RESP;
      end

      ills_pkg::ST_RM_VIC: begin
        sel_nxt   = link_next;
        rd_addr   = link_next;
        state_nxt = ills_pkg::ST_RM_LINK;
      end

      ills_pkg::ST_RM_LINK: begin
        // Unlink the victim from its predecessor.
        link_we    = 1'b1;
        link_waddr = cur_r;
        link_wdata = link_next;
        if (sel_r == tail_r) begin
          tail_nxt = cur_r;
        end
        state_nxt = ills_pkg::ST_GIVE;
      end

      ills_pkg::ST_RM_HEAD: begin
        head_nxt  = link_next;
        state_nxt = ills_pkg::ST_GIVE;
      end

      ills_pkg::ST_GIVE: begin
        // Push the victim onto the free list.
        link_we        = 1'b1;
        link_waddr     = sel_r;
        link_wdata     = clamp_slot(free_head_r);
        free_head_nxt  = sel_r;
        free_count_nxt = free_count_r + CW'(1);
        count_nxt      = count_r - CW'(1);
        rsp_ok_nxt     = 1'b1;
        state_nxt      = ills_pkg::ST_RESP;
      end

      ills_pkg::ST_RESP: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.read_value  = rsp_value_r;
          out_data_nxt.ok          = rsp_ok_r;
          out_data_nxt.full_drop   = rsp_drop_r;
          out_data_nxt.entry_count = EW'(count_r);
          state_nxt                = ills_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = ills_pkg::ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ills_pkg::ST_IDLE;
      head_r       <= '0;
      tail_r       <= '0;
      free_head_r  <= '0;
      count_r      <= '0;
      free_count_r <= '0;
      fresh_r      <= '0;
      hop_r        <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      head_r       <= head_nxt;
      tail_r       <= tail_nxt;
      free_head_r  <= free_head_nxt;
      count_r      <= count_nxt;
      free_count_r <= free_count_nxt;
      fresh_r      <= fresh_nxt;
      hop_r        <= hop_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    nv_r        <= nv_nxt;
    cur_r       <= cur_nxt;
    sel_r       <= sel_nxt;
    steps_r     <= steps_nxt;
    rsp_value_r <= rsp_value_nxt;
    rsp_ok_r    <= rsp_ok_nxt;
    rsp_drop_r  <= rsp_drop_nxt;
    out_data_r  <= out_data_nxt;
  end

  // Every slot handed out is either in the list or on the free list.
  `ILLS_ASSERT_NOW(a_slot_balance, clk, rst_n, in_ready, used_slots == (CW+1)'(fresh_r))
  // The list never grows past the store.
  `ILLS_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, count_r <= CW'(CAPACITY))
  // A refused insert never reports success.
  `ILLS_ASSERT_NOW(a_drop_not_ok, clk, rst_n, out_valid_r && out_data_r.full_drop, !out_data_r.ok)
  // A finished response is presented on the next cycle.
  `ILLS_ASSERT_NEXT(a_resp_lands, clk, rst_n, resp_fire, out_valid_r && in_ready)

endmodule

>>> tb/ills_list_checker.sv
`timescale 1ns / 1ps
// Response checker for the indexed linked list store unit: list model and field comparison.
module ills_list_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  ills_pkg::ills_in_t  in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  ills_pkg::ills_out_t out_data,
  output int                  fail_count,
  output int                  owed_count
);

  localparam int SLOTS  = 64;
  localparam int SLOT_W = 6;

  // Model copy of the slot store and list registers.
  logic signed [ills_pkg::WORD_W-1:0] slot_val  [SLOTS];
  logic [SLOT_W-1:0]                  slot_next [SLOTS];
  logic [SLOT_W-1:0]                  head_slot, tail_slot, free_head;
  logic [ills_pkg::COUNT_W-1:0]       list_len, free_len, fresh_mark;

  ills_pkg::ills_out_t responses_owed[$];

  initial begin
    fail_count = 0;
    owed_count = 0;
  end

  task automatic report_mismatch(input string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    fail_count++;
  endtask

  function automatic logic [SLOT_W-1:0] slot_at(input int steps);
    logic [SLOT_W-1:0] s;
    s = head_slot;
    for (int i = 0; i < steps; i++) begin
      s = slot_next[s];
    end
    return s;
  endfunction

  function automatic ills_pkg::ills_out_t apply_list_op(input ills_pkg::ills_in_t req);
    ills_pkg::ills_out_t r;
    logic [SLOT_W-1:0]   s;
    logic [SLOT_W-1:0]   prev;
    logic [SLOT_W-1:0]   victim;
    r = '0;
    case (req.opcode) inside
      ills_pkg::OP_READ: begin
        if (req.list_position < list_len) begin
          r.read_value = slot_val[slot_at(int'(req.list_position))];
          r.ok         = 1'b1;
        end else begin
          r.read_value = ills_pkg::READ_FAIL;
        end
      end
      ills_pkg::OP_INS_HEAD, ills_pkg::OP_INS_TAIL: begin
        if (list_len >= SLOTS) begin
          r.full_drop = 1'b1;
        end else begin
          // recycled slots first, then fresh ones in order
          if (free_len > 0) begin
            s         = free_head;
            free_head = slot_next[s];
            free_len--;
          end else begin
            s = fresh_mark[SLOT_W-1:0];
            fresh_mark++;
          end
          slot_val[s] = req.new_value;
          if (list_len == 0) begin
            head_slot = s;
            tail_slot = s;
          end else if (req.opcode == ills_pkg::OP_INS_HEAD) begin
            slot_next[s] = head_slot;
            head_slot    = s;
          end else begin
            slot_next[tail_slot] = s;
            tail_slot            = s;
          end
          list_len++;
          r.ok = 1'b1;
        end
      end
      default: begin
        if (req.list_position < list_len) begin
          if (req.list_position == 0) begin
            victim    = head_slot;
            head_slot = slot_next[victim];
          end else begin
            prev            = slot_at(int'(req.list_position) - 1);
            victim          = slot_next[prev];
            slot_next[prev] = slot_next[victim];
            if (victim == tail_slot) begin
              tail_slot = prev;
            end
          end
          slot_next[victim] = free_head;
          free_head         = victim;
          free_len++;
          list_len--;
          r.ok = 1'b1;
        end
      end
    endcase
    r.entry_count = list_len;
    return r;
  endfunction

  always @(posedge clk) begin
    ills_pkg::ills_out_t want;
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) begin
        slot_val[i]  = '0;
        slot_next[i] = '0;
      end
      head_slot  = '0;
      tail_slot  = '0;
      free_head  = '0;
      list_len   = '0;
      free_len   = '0;
      fresh_mark = '0;
      responses_owed.delete();
    end else begin
      if (in_valid && in_ready) begin
        responses_owed.push_back(apply_list_op(in_data));
      end
      if (out_valid && out_ready) begin
        if (responses_owed.size() == 0) begin
          report_mismatch($sformatf("response with no request pending (count %0d)",
                                    out_data.entry_count));
        end else begin
          want = responses_owed.pop_front();
          if (out_data.read_value !== want.read_value)
            report_mismatch($sformatf("read_value got %0d want %0d",
                                      out_data.read_value, want.read_value));
          if (out_data.ok !== want.ok)
            report_mismatch($sformatf("ok got %b want %b", out_data.ok, want.ok));
          if (out_data.full_drop !== want.full_drop)
            report_mismatch($sformatf("full_drop got %b want %b",
                                      out_data.full_drop, want.full_drop));
          if (out_data.entry_count !== want.entry_count)
            report_mismatch($sformatf("entry_count got %0d want %0d",
                                      out_data.entry_count, want.entry_count));
        end
      end
    end
    owed_count = responses_owed.size();
  end

endmodule

>>> tb/tb_indexed_linked_list_store_unit.sv
`timescale 1ns / 1ps
// Testbench top for the indexed linked list store unit: stimulus, flow control and verdict.
module tb_indexed_linked_list_store_unit;

  localparam int CAPACITY       = 64;
  localparam int RANDOM_ITEMS   = 1250;
  localparam int MAX_GAP        = 18;
  // long receiver hold-off so the unit backs up and drops in_ready
  localparam int PRESSURE_AT    = 300;
  localparam int PRESSURE_HOLD  = 400;
  // drain window after the last response
  localparam int TAIL_CYCLES    = 100;
  // the longest honest quiet stretch is set by the receiver hold-off
  localparam int WATCHDOG_LIMIT = 4000;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  ills_pkg::ills_in_t  in_data;
  logic                out_valid;
  logic                out_ready;
  ills_pkg::ills_out_t out_data;

  int fail_count;
  int owed_count;

  // Stimulus-side bookkeeping. list_len shadows the list length only to aim
  // positions at the edges; checking is done in the checker.
  int                 list_len;
  int                 sent_items;
  int                 recv_items;
  int                 idle_cycles;
  ills_pkg::ills_op_t op;
  logic [7:0]         pos;
  logic [31:0]        val;
  int                 roll;
  bit                 grow;

  always #1 clk = ~clk;

  indexed_linked_list_store_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  ills_list_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .fail_count (fail_count),
    .owed_count (owed_count)
  );

  // One request transaction. Entered and left at a falling edge. With no gap
  // in_valid simply stays high for the next transaction.
  task automatic send_request(input ills_pkg::ills_op_t op_i, input logic [7:0] pos_i,
                              input logic [31:0] val_i);
    int gap;
    // every third stretch of 90 requests goes back to back
    gap = (((sent_items / 90) % 3) == 2) ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data  <= ills_pkg::ills_in_t'{opcode: op_i, list_position: pos_i, new_value: val_i};
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    sent_items++;
    case (op_i) inside
      ills_pkg::OP_INS_HEAD, ills_pkg::OP_INS_TAIL: if (list_len < CAPACITY) list_len++;
      ills_pkg::OP_REMOVE:                          if (pos_i < list_len) list_len--;
      default: ;
    endcase
  endtask

  // Main stimulus: reset, directed requests, then random phases.
  initial begin
    in_valid   = 1'b0;
    in_data    = '0;
    rst_n      = 1'b0;
    list_len   = 0;
    sent_items = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // empty list: read and remove both miss
    send_request(ills_pkg::OP_READ,     8'h00, 32'h0000_0000);
    send_request(ills_pkg::OP_REMOVE,   8'h00, 32'hFFFF_FFFF);
    // value extremes, both insert ends; insert ignores the position field
    send_request(ills_pkg::OP_INS_HEAD, 8'hFF, 32'h7FFF_FFFF);
    send_request(ills_pkg::OP_INS_TAIL, 8'h00, 32'h8000_0000);
    send_request(ills_pkg::OP_INS_HEAD, 8'hAA, 32'hFFFF_FFFF);
    send_request(ills_pkg::OP_INS_TAIL, 8'h55, 32'h0000_0000);
    // list is now -1, max, min, 0
    send_request(ills_pkg::OP_READ,     8'h00, 32'h1234_5678);
    send_request(ills_pkg::OP_READ,     8'h03, 32'h0000_0000);
    send_request(ills_pkg::OP_READ,     8'h04, 32'h0000_0000);  // one past the end
    send_request(ills_pkg::OP_READ,     8'hFF, 32'h0000_0000);  // far past the end
    // drop the tail, then append: tail pointer must have moved back
    send_request(ills_pkg::OP_REMOVE,   8'h03, 32'h0000_0000);
    send_request(ills_pkg::OP_INS_TAIL, 8'hFF, 32'h5555_5555);  // reuses the freed slot
    send_request(ills_pkg::OP_READ,     8'h03, 32'h0000_0000);
    send_request(ills_pkg::OP_REMOVE,   8'h01, 32'h0000_0000);  // middle
    send_request(ills_pkg::OP_REMOVE,   8'h00, 32'h0000_0000);  // head
    send_request(ills_pkg::OP_INS_HEAD, 8'h00, 32'hAAAA_AAAA);
    send_request(ills_pkg::OP_REMOVE,   8'h04, 32'h0000_0000);  // bad position, no change
    send_request(ills_pkg::OP_READ,     8'h02, 32'h0000_0000);
    // empty it out, then rebuild from the stale head/tail
    send_request(ills_pkg::OP_REMOVE,   8'h00, 32'h0000_0000);
    send_request(ills_pkg::OP_REMOVE,   8'h00, 32'h0000_0000);
    send_request(ills_pkg::OP_REMOVE,   8'h00, 32'h0000_0000);
    send_request(ills_pkg::OP_READ,     8'h00, 32'h0000_0000);
    send_request(ills_pkg::OP_INS_TAIL, 8'h80, 32'h0000_3039);
    send_request(ills_pkg::OP_READ,     8'h00, 32'h0000_0000);

    // Random part. Grow phases fill the list and hit full drops, shrink
    // phases drain it to empty. A small share is unaimed noise.
    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      grow = ((k / 200) % 2) == 0;
      roll = $urandom_range(0, 99);
      if (roll < 8) begin
        op  = ills_pkg::ills_op_t'($urandom_range(0, 3));
        pos = 8'($urandom_range(0, 255));
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < (grow ? 60 : 20))
          op = $urandom_range(0, 1) ? ills_pkg::OP_INS_HEAD : ills_pkg::OP_INS_TAIL;
        else if (roll < (grow ? 85 : 45)) op = ills_pkg::OP_READ;
        else                              op = ills_pkg::OP_REMOVE;
        roll = $urandom_range(0, 99);
        if (list_len == 0 || roll < 8) pos = 8'($urandom_range(0, 255));
        else if (roll < 22)            pos = 8'd0;
        else if (roll < 36)            pos = 8'(list_len - 1);
        else if (roll < 44)            pos = 8'(list_len);       // just out of range
        else                           pos = 8'($urandom_range(0, list_len - 1));
      end
      roll = $urandom_range(0, 99);
      if (roll < 4)       val = 32'h7FFF_FFFF;
      else if (roll < 8)  val = 32'h8000_0000;
      else if (roll < 11) val = 32'h0000_0000;
      else if (roll < 14) val = 32'hFFFF_FFFF;
      else                val = $urandom;
      send_request(op, pos, val);
    end
    in_valid <= 1'b0;

    // drain, then watch a little longer for stray responses
    while (owed_count != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && owed_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Response side: random ready gaps per transaction, back-to-back stretches,
  // and one long hold-off while requests keep coming.
  initial begin
    int  gap;
    bit  pressure_done;
    out_ready     = 1'b0;
    recv_items    = 0;
    pressure_done = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      gap = (((recv_items / 70) % 3) == 1) ? 0 : $urandom_range(0, MAX_GAP);
      if (!pressure_done && recv_items == PRESSURE_AT) begin
        gap           = PRESSURE_HOLD;
        pressure_done = 1'b1;
      end
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      recv_items++;
      @(negedge clk);
    end
  end

  // Watchdog: quiet cycles on both channels.
  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

endmodule
